// ----- hdl/cou_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table of the camera orientation unit.
// No dependencies; the top, cou_cordic and cou_mul use it by scoped names.
package cou_pkg;

	localparam int DW = 36;   // CORDIC datapath width (Q2.30 plus headroom)
	localparam int MW = 33;   // multiplier operand width
	localparam int PW = 66;   // multiplier product width

	localparam logic signed [DW-1:0] KGAIN   = 36'sd652032874;
	localparam logic signed [DW-1:0] HALF    = 36'sd2147483648;
	localparam logic signed [DW-1:0] QUARTER = 36'sd1073741824;

	localparam logic [1:0] REQ_TURN  = 2'd0;
	localparam logic [1:0] REQ_POINT = 2'd1;
	localparam logic [1:0] REQ_DIR   = 2'd2;

	localparam logic [1:0] CFG_POS_X = 2'd0;
	localparam logic [1:0] CFG_POS_Y = 2'd1;
	localparam logic [1:0] CFG_POS_Z = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] yaw_offset;
		logic signed [15:0] pitch_offset;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
	} req_t;

	typedef struct packed {
		logic [15:0]        pitch_angle;
		logic [15:0]        yaw_angle;
		logic signed [15:0] front_x;
		logic signed [15:0] front_y;
		logic signed [15:0] front_z;
		logic               zero_vector_error;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic rot;
	} cord_ctl_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/cou_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type comes from cou_pkg through the type parameter.
interface cou_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/camera_orientation_unit_top.sv -----
// Camera orientation unit: pitch/yaw state, look-at solving and front vector output.
// Turn item or unused code: pitch and yaw rotations only. Look item: normalization, yaw and
// pitch vectoring, then the rotations (straight up or down skips yaw vectoring; a zero vector
// skips normalization and vectoring). One item at a time: ready returns in the cycle after
// the result is loaded; a result still held by the sink stalls the sequencer in its last state.
// Reset (arst_n low, asynchronous) clears angles, camera position and the sequencer.
module camera_orientation_unit_top #(
	parameter int ANGLE_BITS      = 16,
	parameter int CORDIC_STEPS    = 16,
	parameter int FRONT_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	cou_stream_if.sink   req,
	cou_stream_if.source rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);
	localparam int DW = cou_pkg::DW;
	localparam int PW = cou_pkg::PW;
	localparam int MW = cou_pkg::MW;
	localparam int N_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int SHR = 32 - ANGLE_BITS;
	localparam int SH1 = 30 - FRONT_FRAC_BITS;
	localparam int SH2 = 60 - FRONT_FRAC_BITS;
	localparam logic [31:0] RND_A = 32'((33'd1 << SHR) >> 1);
	localparam logic signed [DW-1:0] RND1 = DW'((37'd1 << SH1) >> 1);
	localparam logic signed [PW-1:0] RND2 = PW'(67'd1 << (SH2 - 1));
	localparam logic signed [PW-1:0] LIM = PW'(67'd1 << FRONT_FRAC_BITS);
	localparam logic signed [DW-1:0] M_HI = 36'sd1073741824;
	localparam logic signed [DW-1:0] M_LO = 36'sd536870912;
	localparam logic [4:0] LAST = 5'(N_STEPS - 1);

	// sequencer states
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_CHECK   = 5'd1;
	localparam logic [4:0] S_NDN     = 5'd2;
	localparam logic [4:0] S_NUP     = 5'd3;
	localparam logic [4:0] S_YINIT   = 5'd4;
	localparam logic [4:0] S_YV_RUN  = 5'd5;
	localparam logic [4:0] S_YV_DONE = 5'd6;
	localparam logic [4:0] S_HMUL    = 5'd7;
	localparam logic [4:0] S_HSET    = 5'd8;
	localparam logic [4:0] S_PV_RUN  = 5'd9;
	localparam logic [4:0] S_PV_DONE = 5'd10;
	localparam logic [4:0] S_RP_INIT = 5'd11;
	localparam logic [4:0] S_RP_RUN  = 5'd12;
	localparam logic [4:0] S_RP_DONE = 5'd13;
	localparam logic [4:0] S_RY_INIT = 5'd14;
	localparam logic [4:0] S_RY_RUN  = 5'd15;
	localparam logic [4:0] S_RY_DONE = 5'd16;
	localparam logic [4:0] S_M2      = 5'd17;
	localparam logic [4:0] S_M3      = 5'd18;
	localparam logic [4:0] S_M4      = 5'd19;
	localparam logic [4:0] S_DONE    = 5'd20;

	logic [4:0] state_q;
	logic [4:0] cnt_q;
	logic [ANGLE_BITS-1:0] pitch_q, yaw_q;
	logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [DW-1:0] nx_q, ny_q, nz_q;
	logic [31:0] yaw_t_q;
	logic        err_q;
	logic        rneg_q;
	logic signed [DW-1:0] cp_q, sp_q, sy_q;
	logic signed [15:0] fx_q, fz_q;
	logic        out_valid_q;
	cou_pkg::rsp_t rsp_q;

	cou_pkg::cord_ctl_t   cctl;
	logic signed [DW-1:0] ld_x, ld_y, ld_z;
	logic signed [DW-1:0] cx, cy, cz;
	logic signed [DW-1:0] vx0, vy0;
	logic signed [DW-1:0] rz0, rz_adj;
	logic                 rneg_d;
	logic [31:0]          rang;
	logic                 mul_ld;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [DW-1:0] ax, ay, az, mag;
	logic [31:0]          pitch32, yaw32;
	logic signed [DW-1:0] cneg_x, cneg_y;
	logic signed [DW-1:0] hval;
	logic signed [PW-1:0] fprod_r;
	logic signed [DW-1:0] fy_r;
	logic                 accept, out_load;

	function automatic logic signed [DW-1:0] abs36(input logic signed [DW-1:0] v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [15:0] sat_front(input logic signed [PW-1:0] r);
		logic signed [PW-1:0] s;
		s = r;
		if (r > LIM) s = LIM;
		if (r < -LIM) s = -LIM;
		return s[15:0];
	endfunction

	function automatic logic [ANGLE_BITS-1:0] quant(input logic [31:0] a);
		logic [31:0] t;
		t = (a + RND_A) >> SHR;
		return ANGLE_BITS'(t);
	endfunction

	assign pitch32 = 32'(pitch_q) << SHR;
	assign yaw32   = 32'(yaw_q) << SHR;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

	// largest component magnitude for normalization
	always_comb begin
		ax = abs36(nx_q);
		ay = abs36(ny_q);
		az = abs36(nz_q);
		mag = ax;
		if (ay > mag) mag = ay;
		if (az > mag) mag = az;
	end

	// gain-corrected horizontal length, floor of h*K / 2^30
	assign hval = DW'(prod >>> 30);

	// vectoring start: pick (x0, y0), fold the left half plane
	always_comb begin
		vx0 = hval;
		vy0 = ny_q;
		if (state_q == S_YINIT) begin
			if (nx_q == 0 && nz_q == 0) begin
				vx0 = '0;
				vy0 = ny_q;
			end else begin
				vx0 = -nz_q;
				vy0 = nx_q;
			end
		end
	end

	// rotation start: signed angle folded into the right half plane
	always_comb begin
		rang = (state_q == S_RY_INIT) ? yaw32 : pitch32;
		rz0 = DW'($signed(rang));
		rz_adj = rz0;
		rneg_d = 1'b0;
		if (rz0 > cou_pkg::QUARTER) begin
			rz_adj = rz0 - cou_pkg::HALF;
			rneg_d = 1'b1;
		end else if (rz0 < -cou_pkg::QUARTER) begin
			rz_adj = rz0 + cou_pkg::HALF;
			rneg_d = 1'b1;
		end
	end

	// CORDIC command and load mux
	always_comb begin
		cctl = '0;
		ld_x = cou_pkg::KGAIN;
		ld_y = '0;
		ld_z = rz_adj;
		case (state_q)
			S_YINIT, S_HSET: begin
				cctl.load = 1'b1;
				if (vx0 < 0) begin
					ld_x = -vx0;
					ld_y = -vy0;
					ld_z = cou_pkg::HALF;
				end else begin
					ld_x = vx0;
					ld_y = vy0;
					ld_z = '0;
				end
			end
			S_RP_INIT, S_RY_INIT: begin
				cctl.load = 1'b1;
				cctl.rot = 1'b1;
			end
			S_YV_RUN, S_PV_RUN: cctl.step = 1'b1;
			S_RP_RUN, S_RY_RUN: begin
				cctl.step = 1'b1;
				cctl.rot = 1'b1;
			end
			default: cctl = '0;
		endcase
	end

	assign cneg_x = rneg_q ? -cx : cx;
	assign cneg_y = rneg_q ? -cy : cy;

	// multiplier operand mux
	always_comb begin
		mul_ld = 1'b0;
		mul_a = MW'(cx);
		mul_b = MW'(cou_pkg::KGAIN);
		case (state_q)
			S_YV_DONE: mul_ld = 1'b1;
			S_RY_DONE: begin
				mul_ld = 1'b1;
				mul_a = MW'(cp_q);
				mul_b = MW'(cneg_x);
			end
			S_M2: begin
				mul_ld = 1'b1;
				mul_a = MW'(cp_q);
				mul_b = MW'(sy_q);
			end
			default: mul_ld = 1'b0;
		endcase
	end

	// round half up onto the front vector grid
	assign fprod_r = (prod + RND2) >>> SH2;
	assign fy_r    = (sp_q + RND1) >>> SH1;

	cou_cordic u_cordic (
		.clk  (clk),
		.ctl  (cctl),
		.idx  (cnt_q),
		.ld_x (ld_x),
		.ld_y (ld_y),
		.ld_z (ld_z),
		.x    (cx),
		.y    (cy),
		.z    (cz)
	);

	cou_mul u_mul (
		.clk  (clk),
		.ld   (mul_ld),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// camera position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				cou_pkg::CFG_POS_X: pos_x_q <= cfg_wdata;
				cou_pkg::CFG_POS_Y: pos_y_q <= cfg_wdata;
				cou_pkg::CFG_POS_Z: pos_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer and angle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.data.req_type)
							cou_pkg::REQ_TURN: begin
								yaw_q <= yaw_q +
									ANGLE_BITS'({req.data.yaw_offset, 16'h0000} >> SHR);
								pitch_q <= pitch_q +
									ANGLE_BITS'({req.data.pitch_offset, 16'h0000} >> SHR);
								state_q <= S_RP_INIT;
							end
							cou_pkg::REQ_POINT, cou_pkg::REQ_DIR: state_q <= S_CHECK;
							default: state_q <= S_RP_INIT;
						endcase
					end
				end
				S_CHECK: state_q <= (nx_q == 0 && ny_q == 0 && nz_q == 0) ? S_RP_INIT : S_NDN;
				S_NDN: if (mag < M_HI) state_q <= S_NUP;
				S_NUP: if (mag >= M_LO) state_q <= S_YINIT;
				S_YINIT: begin
					cnt_q <= '0;
					state_q <= (nx_q == 0 && nz_q == 0) ? S_PV_RUN : S_YV_RUN;
				end
				S_YV_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST) state_q <= S_YV_DONE;
				end
				S_YV_DONE: state_q <= S_HMUL;
				S_HMUL: state_q <= S_HSET;
				S_HSET: begin
					cnt_q <= '0;
					state_q <= S_PV_RUN;
				end
				S_PV_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST) state_q <= S_PV_DONE;
				end
				S_PV_DONE: begin
					pitch_q <= quant(cz[31:0]);
					yaw_q <= quant(yaw_t_q);
					state_q <= S_RP_INIT;
				end
				S_RP_INIT: begin
					cnt_q <= '0;
					state_q <= S_RP_RUN;
				end
				S_RP_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST) state_q <= S_RP_DONE;
				end
				S_RP_DONE: state_q <= S_RY_INIT;
				S_RY_INIT: begin
					cnt_q <= '0;
					state_q <= S_RY_RUN;
				end
				S_RY_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST) state_q <= S_RY_DONE;
				end
				S_RY_DONE: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				err_q <= 1'b0;
				if (req.data.req_type == cou_pkg::REQ_POINT) begin
					nx_q <= DW'(req.data.target_x) - DW'(pos_x_q);
					ny_q <= DW'(req.data.target_y) - DW'(pos_y_q);
					nz_q <= DW'(req.data.target_z) - DW'(pos_z_q);
				end else begin
					nx_q <= DW'(req.data.target_x);
					ny_q <= DW'(req.data.target_y);
					nz_q <= DW'(req.data.target_z);
				end
			end
			S_CHECK: err_q <= (nx_q == 0 && ny_q == 0 && nz_q == 0);
			S_NDN: begin
				// halve until every component is below a quarter turn
				if (mag >= M_HI) begin
					nx_q <= nx_q >>> 1;
					ny_q <= ny_q >>> 1;
					nz_q <= nz_q >>> 1;
				end
			end
			S_NUP: begin
				// double until the largest component reaches an eighth turn
				if (mag < M_LO) begin
					nx_q <= nx_q <<< 1;
					ny_q <= ny_q <<< 1;
					nz_q <= nz_q <<< 1;
				end
			end
			S_YINIT: yaw_t_q <= 32'(cou_pkg::QUARTER);
			S_YV_DONE: yaw_t_q <= cz[31:0] - 32'(cou_pkg::QUARTER);
			S_RP_INIT, S_RY_INIT: rneg_q <= rneg_d;
			S_RP_DONE: begin
				cp_q <= cneg_x;
				sp_q <= cneg_y;
			end
			S_RY_DONE: sy_q <= cneg_y;
			S_M3: fx_q <= sat_front(fprod_r);
			S_M4: fz_q <= sat_front(fprod_r);
			S_DONE: begin
				if (out_load) begin
					rsp_q.pitch_angle <= pitch32[31:16];
					rsp_q.yaw_angle <= yaw32[31:16];
					rsp_q.front_x <= fx_q;
					rsp_q.front_y <= sat_front(PW'(fy_r));
					rsp_q.front_z <= fz_q;
					rsp_q.zero_vector_error <= err_q;
				end
			end
			default: ;
		endcase
	end

	// an accepted transaction always starts the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer did not leave idle after a transaction");

	// iteration index never runs past the last CORDIC step while stepping
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_YV_RUN || state_q == S_PV_RUN || state_q == S_RP_RUN ||
			state_q == S_RY_RUN) |-> cnt_q <= LAST)
		else $error("CORDIC step index out of range");

	// upward normalization never lifts a component to a quarter turn
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NUP |-> mag < M_HI)
		else $error("normalized look vector overflowed");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> $stable(rsp_q))
		else $error("held result changed");
endmodule

// ----- hdl/cou_cordic.sv -----
// Shared CORDIC iteration unit: x/y/z registers, one micro-rotation per step.
// Uses cou_pkg for widths, control struct and the arctangent table.
module cou_cordic (
	input  logic                            clk,
	input  cou_pkg::cord_ctl_t              ctl,
	input  logic [4:0]                      idx,
	input  logic signed [cou_pkg::DW-1:0]   ld_x,
	input  logic signed [cou_pkg::DW-1:0]   ld_y,
	input  logic signed [cou_pkg::DW-1:0]   ld_z,
	output logic signed [cou_pkg::DW-1:0]   x,
	output logic signed [cou_pkg::DW-1:0]   y,
	output logic signed [cou_pkg::DW-1:0]   z
);
	logic signed [cou_pkg::DW-1:0] x_q, y_q, z_q;
	logic signed [cou_pkg::DW-1:0] dx, dy, at;
	logic                          sig_pos;

	always_comb begin
		dx = x_q >>> idx;
		dy = y_q >>> idx;
		at = cou_pkg::DW'(cou_pkg::atan_turn(idx));
		// rotation drives z to zero, vectoring drives y to zero
		sig_pos = ctl.rot ? (z_q >= 0) : (y_q < 0);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= ld_x;
			y_q <= ld_y;
			z_q <= ld_z;
		end else if (ctl.step) begin
			if (sig_pos) begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
				z_q <= z_q + at;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
endmodule

// ----- hdl/cou_mul.sv -----
// Shared signed multiplier with registered operands and registered product.
// Uses cou_pkg for operand and product widths.
module cou_mul (
	input  logic                          clk,
	input  logic                          ld,
	input  logic signed [cou_pkg::MW-1:0] a,
	input  logic signed [cou_pkg::MW-1:0] b,
	output logic signed [cou_pkg::PW-1:0] prod
);
	logic signed [cou_pkg::MW-1:0] a_q, b_q;
	logic signed [cou_pkg::PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			a_q <= a;
			b_q <= b;
		end
		prod_q <= a_q * b_q;
	end

	assign prod = prod_q;
endmodule
